// ===== src/ltpg_pkg.sv =====
// ----------------------------------------------------------------------------
// LED trail pattern generator package
// Shared types, register indexes, device codes, the sequencer program and the
// mapping from logical positions to strip pixels.
// ----------------------------------------------------------------------------
package ltpg_pkg;

	// Number of logical LED positions around the display.
	localparam int RING_POSITIONS = 48;
	// Default upper clamp for the trail length.
	localparam int MAX_TRAIL_LENGTH_DEF = 48;
	// Lowest usable trail length.
	localparam int MIN_TRAIL_LENGTH = 2;

	localparam int POS_W = 6;
	localparam int COLOR_W = 8;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W = 8;
	localparam int NUM_LANES = 3;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] REG_TRAIL_LENGTH = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_START_RED = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_START_GREEN = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_START_BLUE = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_END_RED = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_END_GREEN = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_END_BLUE = 3'd6;

	// Register reset values.
	localparam logic [POS_W-1:0] TRAIL_LENGTH_RST = 6'd8;
	localparam logic [COLOR_W-1:0] START_RED_RST = 8'd0;
	localparam logic [COLOR_W-1:0] START_GREEN_RST = 8'd0;
	localparam logic [COLOR_W-1:0] START_BLUE_RST = 8'd255;
	localparam logic [COLOR_W-1:0] END_RED_RST = 8'd0;
	localparam logic [COLOR_W-1:0] END_GREEN_RST = 8'd0;
	localparam logic [COLOR_W-1:0] END_BLUE_RST = 8'd10;

	// Target strips.
	localparam logic [1:0] DEV_RIGHT_RING = 2'd0;
	localparam logic [1:0] DEV_MIDDLE_BAR = 2'd1;
	localparam logic [1:0] DEV_LEFT_RING = 2'd2;

	// Start shifts of the two rings.
	localparam logic [3:0] RIGHT_RING_SHIFT = 4'd1;
	localparam logic [3:0] LEFT_RING_SHIFT = 4'd9;

	typedef struct packed {
		logic [1:0] dev;
		logic [3:0] idx;
	} pix_addr_t;

	// Sequencer micro-operations.
	typedef enum logic [2:0] {
		OP_IDLE,
		OP_SETUP,
		OP_DIV,
		OP_SCALE,
		OP_TRAIL,
		OP_BLANK,
		OP_FINISH
	} uop_t;

	// Jump conditions; when the condition holds the program counter loads the
	// target, otherwise it moves to the next step.
	typedef enum logic [2:0] {
		C_NEVER,
		C_ALWAYS,
		C_NO_TICK,
		C_DIV_MORE,
		C_TRAIL_MORE,
		C_BLANK_HOLD
	} cond_t;

	localparam int PC_W = 3;
	localparam int UCODE_DEPTH = 1 << PC_W;
	typedef logic [PC_W-1:0] pc_t;

	localparam pc_t PC_IDLE = 3'd0;
	localparam pc_t PC_SETUP = 3'd1;
	localparam pc_t PC_DIV = 3'd2;
	localparam pc_t PC_SCALE = 3'd3;
	localparam pc_t PC_TRAIL = 3'd4;
	localparam pc_t PC_BLANK = 3'd5;
	localparam pc_t PC_FINISH = 3'd6;
	localparam pc_t PC_SPARE = 3'd7;

	typedef struct packed {
		uop_t op;
		cond_t cond;
		pc_t target;
	} ucode_t;

	// The program: one control word per step.
	localparam ucode_t UCODE [UCODE_DEPTH] = '{
		'{op: OP_IDLE, cond: C_NO_TICK, target: PC_IDLE},
		'{op: OP_SETUP, cond: C_NEVER, target: PC_IDLE},
		'{op: OP_DIV, cond: C_DIV_MORE, target: PC_DIV},
		'{op: OP_SCALE, cond: C_NEVER, target: PC_IDLE},
		'{op: OP_TRAIL, cond: C_TRAIL_MORE, target: PC_TRAIL},
		'{op: OP_BLANK, cond: C_BLANK_HOLD, target: PC_BLANK},
		'{op: OP_FINISH, cond: C_ALWAYS, target: PC_IDLE},
		'{op: OP_FINISH, cond: C_ALWAYS, target: PC_IDLE}
	};

	// Map a logical position to its strip and pixel number.
	function automatic pix_addr_t map_position(input logic [POS_W-1:0] pos);
		pix_addr_t a;
		logic [POS_W-1:0] rel;
		if (pos <= 6'd15) begin
			a.dev = DEV_RIGHT_RING;
			a.idx = pos[3:0] + RIGHT_RING_SHIFT;
		end else if (pos <= 6'd23) begin
			rel = pos - 6'd16;
			a.dev = DEV_MIDDLE_BAR;
			a.idx = rel[3:0];
		end else if (pos <= 6'd39) begin
			rel = pos - 6'd24;
			a.dev = DEV_LEFT_RING;
			a.idx = rel[3:0] + LEFT_RING_SHIFT;
		end else begin
			rel = pos - 6'd32;
			a.dev = DEV_MIDDLE_BAR;
			a.idx = rel[3:0];
		end
		return a;
	endfunction

endpackage

// ===== src/led_trail_pattern_generator.sv =====
// ----------------------------------------------------------------------------
// LED trail pattern generator
// Each accepted tick paints a colour trail of L pixels (the trail length
// clamped to 2..MAX_TRAIL_LENGTH) over 48 logical positions starting at the
// head, then blanks the pixel behind the head except on the first tick after
// reset or restart, and advances the head. One pixel write leaves per result
// request; the last one of a tick carries last_write. A tick passes through
// an accept step, a setup step, the restoring divider that forms the three
// colour steps one quotient bit per cycle, one scaling multiply, L trail
// writes, one blank write and a step that advances the head; trail and blank
// writes wait while the output is stalled. A restart request produces no
// writes and leaves the block idle. Configuration writes are taken at any time
// but must only be issued while no tick is in progress.
// ----------------------------------------------------------------------------
module led_trail_pattern_generator
	import ltpg_pkg::*;
#(
	parameter int MAX_TRAIL_LENGTH = MAX_TRAIL_LENGTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// Configuration port
	input  logic                   cfg_write_en,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	// Tick requests
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic                   restart,
	// Pixel writes
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [1:0]             device_select,
	output logic [3:0]             pixel_index,
	output logic [COLOR_W-1:0]     red_level,
	output logic [COLOR_W-1:0]     green_level,
	output logic [COLOR_W-1:0]     blue_level,
	output logic                   last_write
);

	localparam logic [POS_W-1:0] MAX_LEN = POS_W'(MAX_TRAIL_LENGTH);
	localparam logic [POS_W-1:0] MIN_LEN = POS_W'(MIN_TRAIL_LENGTH);
	localparam logic [POS_W-1:0] LAST_POS = POS_W'(RING_POSITIONS - 1);
	localparam logic [POS_W:0] RING_WIDE = (POS_W+1)'(RING_POSITIONS);

	// Configuration registers.
	logic [POS_W-1:0] trail_length_q;
	logic [COLOR_W-1:0] start_q [NUM_LANES];
	logic [COLOR_W-1:0] end_q [NUM_LANES];

	// Sequencer and datapath state.
	pc_t pc_q;
	logic [2:0] bit_cnt_q;
	logic [POS_W-1:0] head_q;
	logic first_q;
	logic [POS_W-1:0] idx_q;
	logic [POS_W-1:0] pos_q;
	logic [POS_W-1:0] divisor_q;
	logic [COLOR_W-1:0] num_q [NUM_LANES];
	logic [POS_W-1:0] rem_q [NUM_LANES];
	logic neg_q [NUM_LANES];
	logic [COLOR_W-1:0] step_q [NUM_LANES];
	logic [COLOR_W-1:0] acc_q [NUM_LANES];

	// Output register.
	logic out_valid_q;
	pix_addr_t out_addr_q;
	logic [COLOR_W-1:0] out_col_q [NUM_LANES];
	logic out_last_q;

	// Decode and control signals.
	ucode_t uw;
	logic tick;
	logic restart_take;
	logic load_ok;
	logic jump;
	logic [POS_W-1:0] len_eff;
	logic [POS_W:0] pos_sum;
	logic [POS_W-1:0] pos_first;
	logic [POS_W-1:0] blank_pos;
	logic [COLOR_W-1:0] step_val [NUM_LANES];
	logic [COLOR_W-1:0] scaled [NUM_LANES];
	logic [POS_W:0] trial [NUM_LANES];
	logic trial_ge [NUM_LANES];
	logic [POS_W:0] trial_diff [NUM_LANES];

	// Current control word and handshake terms.
	always_comb begin
		uw = UCODE[pc_q];
		in_stall = (uw.op != OP_IDLE);
		tick = in_valid && !in_stall && !restart;
		restart_take = in_valid && !in_stall && restart;
		load_ok = !out_valid_q || !out_stall;
	end

	// Jump condition evaluation.
	always_comb begin
		unique case (uw.cond)
			C_NEVER: jump = 1'b0;
			C_ALWAYS: jump = 1'b1;
			C_NO_TICK: jump = !tick;
			C_DIV_MORE: jump = (bit_cnt_q != 3'd0);
			C_TRAIL_MORE: jump = !load_ok || (idx_q != '0);
			C_BLANK_HOLD: jump = !first_q && !load_ok;
			default: jump = 1'b0;
		endcase
	end

	// Trail length clamp, first trail position and blank position.
	always_comb begin
		if (trail_length_q < MIN_LEN) begin
			len_eff = MIN_LEN;
		end else if (trail_length_q > MAX_LEN) begin
			len_eff = MAX_LEN;
		end else begin
			len_eff = trail_length_q;
		end
		pos_sum = {1'b0, head_q} + {1'b0, len_eff} - (POS_W+1)'(1);
		if (pos_sum >= RING_WIDE) begin
			pos_first = POS_W'(pos_sum - RING_WIDE);
		end else begin
			pos_first = pos_sum[POS_W-1:0];
		end
		blank_pos = (head_q == '0) ? LAST_POS : head_q - POS_W'(1);
	end

	// Divider trial subtraction and step scaling, one set per colour lane.
	always_comb begin
		for (int k = 0; k < NUM_LANES; k++) begin
			trial[k] = {rem_q[k], num_q[k][COLOR_W-1]};
			trial_ge[k] = (trial[k] >= {1'b0, divisor_q});
			trial_diff[k] = trial[k] - {1'b0, divisor_q};
			step_val[k] = neg_q[k] ? COLOR_W'(0) - num_q[k] : num_q[k];
			scaled[k] = end_q[k] + COLOR_W'(14'(idx_q) * 14'(step_val[k]));
		end
	end

	// Configuration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trail_length_q <= TRAIL_LENGTH_RST;
			start_q[0] <= START_RED_RST;
			start_q[1] <= START_GREEN_RST;
			start_q[2] <= START_BLUE_RST;
			end_q[0] <= END_RED_RST;
			end_q[1] <= END_GREEN_RST;
			end_q[2] <= END_BLUE_RST;
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				REG_TRAIL_LENGTH: trail_length_q <= cfg_data[POS_W-1:0];
				REG_START_RED: start_q[0] <= cfg_data;
				REG_START_GREEN: start_q[1] <= cfg_data;
				REG_START_BLUE: start_q[2] <= cfg_data;
				REG_END_RED: end_q[0] <= cfg_data;
				REG_END_GREEN: end_q[1] <= cfg_data;
				REG_END_BLUE: end_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_IDLE;
			head_q <= '0;
			first_q <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			pc_q <= jump ? uw.target : pc_q + pc_t'(1);
			if (restart_take) begin
				head_q <= '0;
				first_q <= 1'b1;
			end
			if (uw.op == OP_FINISH) begin
				head_q <= (head_q == LAST_POS) ? '0 : head_q + POS_W'(1);
				first_q <= 1'b0;
			end
			if ((uw.op == OP_TRAIL && load_ok) ||
					(uw.op == OP_BLANK && !first_q && load_ok)) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers driven by the current micro-operation.
	always_ff @(posedge clk) begin
		unique case (uw.op)
			OP_SETUP: begin
				divisor_q <= len_eff - POS_W'(1);
				idx_q <= len_eff - POS_W'(1);
				pos_q <= pos_first;
				bit_cnt_q <= 3'd7;
				for (int k = 0; k < NUM_LANES; k++) begin
					neg_q[k] <= (start_q[k] < end_q[k]);
					num_q[k] <= (start_q[k] < end_q[k]) ? end_q[k] - start_q[k]
						: start_q[k] - end_q[k];
					rem_q[k] <= '0;
				end
			end
			OP_DIV: begin
				bit_cnt_q <= bit_cnt_q - 3'd1;
				for (int k = 0; k < NUM_LANES; k++) begin
					rem_q[k] <= trial_ge[k] ? trial_diff[k][POS_W-1:0]
						: trial[k][POS_W-1:0];
					num_q[k] <= {num_q[k][COLOR_W-2:0], trial_ge[k]};
				end
			end
			OP_SCALE: begin
				for (int k = 0; k < NUM_LANES; k++) begin
					step_q[k] <= step_val[k];
					acc_q[k] <= scaled[k];
				end
			end
			OP_TRAIL: begin
				if (load_ok) begin
					out_addr_q <= map_position(pos_q);
					out_last_q <= (idx_q == '0) && first_q;
					idx_q <= idx_q - POS_W'(1);
					pos_q <= (pos_q == '0) ? LAST_POS : pos_q - POS_W'(1);
					for (int k = 0; k < NUM_LANES; k++) begin
						out_col_q[k] <= acc_q[k];
						acc_q[k] <= acc_q[k] - step_q[k];
					end
				end
			end
			OP_BLANK: begin
				if (!first_q && load_ok) begin
					out_addr_q <= map_position(blank_pos);
					out_last_q <= 1'b1;
					for (int k = 0; k < NUM_LANES; k++) begin
						out_col_q[k] <= '0;
					end
				end
			end
			default: ;
		endcase
	end

	// Output ports.
	assign out_valid = out_valid_q;
	assign device_select = out_addr_q.dev;
	assign pixel_index = out_addr_q.idx;
	assign red_level = out_col_q[0];
	assign green_level = out_col_q[1];
	assign blue_level = out_col_q[2];
	assign last_write = out_last_q;

endmodule

// ===== src/ltpg_checker.sv =====
// ----------------------------------------------------------------------------
// LED trail pattern generator checker
// Port-level assertions on tick acceptance and pixel write requests.
// ----------------------------------------------------------------------------
module ltpg_checker
	import ltpg_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               restart,
	input logic               out_valid,
	input logic               out_stall,
	input logic [1:0]         device_select,
	input logic [3:0]         pixel_index,
	input logic [COLOR_W-1:0] red_level,
	input logic [COLOR_W-1:0] green_level,
	input logic [COLOR_W-1:0] blue_level,
	input logic               last_write
);

	// A stalled pixel write holds its contents.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(device_select) &&
			$stable(pixel_index) && $stable(red_level) && $stable(green_level) &&
			$stable(blue_level) && $stable(last_write))
	else $error("stalled pixel write changed");

	// An animation tick occupies the block in the following cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !restart |=> in_stall)
	else $error("tick accepted but block did not go busy");

	// A restart request leaves the block free in the following cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && restart |=> !in_stall)
	else $error("restart request kept the block busy");

	// Only the three strips are ever addressed.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> device_select == DEV_RIGHT_RING ||
			device_select == DEV_MIDDLE_BAR || device_select == DEV_LEFT_RING)
	else $error("pixel write to an unknown strip");

endmodule

bind led_trail_pattern_generator ltpg_checker u_ltpg_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_stall(in_stall),
	.restart(restart),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.device_select(device_select),
	.pixel_index(pixel_index),
	.red_level(red_level),
	.green_level(green_level),
	.blue_level(blue_level),
	.last_write(last_write)
);

// ===== sim/ltpg_write_checker.sv =====
// ----------------------------------------------------------------------------
// Pixel write checker for the LED trail pattern generator
// Watches the configuration port and both request channels, keeps its own copy
// of the trail registers, head and first-tick flag, predicts the pixel writes
// of every accepted tick request and compares each accepted write with the
// oldest prediction, field by field.
// ----------------------------------------------------------------------------
module ltpg_write_checker
	import ltpg_pkg::*;
#(
	parameter int MAX_TRAIL_LENGTH = MAX_TRAIL_LENGTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_write_en,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   in_valid,
	input  logic                   in_stall,
	input  logic                   restart,
	input  logic                   out_valid,
	input  logic                   out_stall,
	input  logic [1:0]             device_select,
	input  logic [3:0]             pixel_index,
	input  logic [COLOR_W-1:0]     red_level,
	input  logic [COLOR_W-1:0]     green_level,
	input  logic [COLOR_W-1:0]     blue_level,
	input  logic                   last_write,
	output int                     fail_count,
	output int                     pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [1:0]         dev;
		logic [3:0]         idx;
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
		logic               last;
	} pixel_write_t;

	pixel_write_t expected_writes[$];
	int errors = 0;

	// Shadow copy of the trail registers and of the animation state.
	logic [POS_W-1:0]   trail_length;
	logic [COLOR_W-1:0] start_red, start_green, start_blue;
	logic [COLOR_W-1:0] end_red, end_green, end_blue;
	logic [POS_W-1:0]   head;
	logic               fresh;

	// Builds one pixel write from a logical position and a colour.
	function automatic pixel_write_t pixel_at(input int pos, input int r, input int g,
			input int b, input logic last);
		pixel_write_t w;
		if (pos <= 15) begin
			w.dev = DEV_RIGHT_RING;
			w.idx = 4'((pos + 1) % 16);
		end else if (pos <= 23) begin
			w.dev = DEV_MIDDLE_BAR;
			w.idx = 4'(pos - 16);
		end else if (pos <= 39) begin
			w.dev = DEV_LEFT_RING;
			w.idx = 4'((pos - 24 + 9) % 16);
		end else begin
			w.dev = DEV_MIDDLE_BAR;
			w.idx = 4'(pos - 40 + 8);
		end
		w.red = 8'(r);
		w.green = 8'(g);
		w.blue = 8'(b);
		w.last = last;
		return w;
	endfunction

	// Colour change per trail pixel, truncated toward zero.
	function automatic int channel_slope(input logic [COLOR_W-1:0] s,
			input logic [COLOR_W-1:0] e, input int span);
		int si;
		int ei;
		si = s;
		ei = e;
		return (si - ei) / span;
	endfunction

	// Queues the writes of one animation tick and advances the head.
	function automatic void paint_tick();
		int len;
		int i;
		int step_r, step_g, step_b;
		int er, eg, eb;
		len = trail_length;
		if (len < MIN_TRAIL_LENGTH)
			len = MIN_TRAIL_LENGTH;
		if (len > MAX_TRAIL_LENGTH)
			len = MAX_TRAIL_LENGTH;
		step_r = channel_slope(start_red, end_red, len - 1);
		step_g = channel_slope(start_green, end_green, len - 1);
		step_b = channel_slope(start_blue, end_blue, len - 1);
		er = end_red;
		eg = end_green;
		eb = end_blue;
		for (i = len - 1; i >= 0; i--) begin
			expected_writes.push_back(pixel_at((head + i) % RING_POSITIONS,
				er + i * step_r, eg + i * step_g, eb + i * step_b, (i == 0) && fresh));
		end
		// The pixel behind the head goes dark, except on the first tick after reset or restart.
		if (!fresh)
			expected_writes.push_back(pixel_at((head + RING_POSITIONS - 1) % RING_POSITIONS,
				0, 0, 0, 1'b1));
		head = POS_W'((head + 1) % RING_POSITIONS);
		fresh = 1'b0;
	endfunction

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			errors++;
		end
	endtask

	// Results are retired before new tick requests are predicted, since a write
	// leaving at the same edge always belongs to an earlier request.
	always @(posedge clk) begin
		pixel_write_t want;
		if (!arst_n) begin
			trail_length = TRAIL_LENGTH_RST;
			start_red = START_RED_RST;
			start_green = START_GREEN_RST;
			start_blue = START_BLUE_RST;
			end_red = END_RED_RST;
			end_green = END_GREEN_RST;
			end_blue = END_BLUE_RST;
			head = '0;
			fresh = 1'b1;
			expected_writes.delete();
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_writes.size() == 0) begin
					$display("%0t ns: unexpected pixel write dev %0d idx %0d rgb %0d %0d %0d last %0d",
						$time, device_select, pixel_index, red_level, green_level,
						blue_level, last_write);
					errors++;
				end else begin
					want = expected_writes.pop_front();
					check_field("device_select", want.dev, device_select);
					check_field("pixel_index", want.idx, pixel_index);
					check_field("red_level", want.red, red_level);
					check_field("green_level", want.green, green_level);
					check_field("blue_level", want.blue, blue_level);
					check_field("last_write", want.last, last_write);
				end
			end
			if (cfg_write_en) begin
				case (cfg_index)
					REG_TRAIL_LENGTH: trail_length = cfg_data[POS_W-1:0];
					REG_START_RED: start_red = cfg_data;
					REG_START_GREEN: start_green = cfg_data;
					REG_START_BLUE: start_blue = cfg_data;
					REG_END_RED: end_red = cfg_data;
					REG_END_GREEN: end_green = cfg_data;
					REG_END_BLUE: end_blue = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				if (restart) begin
					head = '0;
					fresh = 1'b1;
				end else begin
					paint_tick();
				end
			end
		end
		pending <= expected_writes.size();
		fail_count <= errors;
	end

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// LED trail pattern generator testbench
// Drives tick and restart requests and register settings into the block, with
// random gaps and stalls on both channels and one long output hold-off, while
// the pixel write checker predicts and compares every write.
// ----------------------------------------------------------------------------
module testbench
	import ltpg_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;
	localparam int SETTLE_CYCLES = 20;
	localparam int HOLD_CYCLES = 400;
	localparam int RANDOM_TICKS = 350;
	localparam int DRAIN_LIMIT = 20000;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_write_en = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;
	logic                   in_valid = 1'b0;
	logic                   in_stall;
	logic                   restart = 1'b0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic [1:0]             device_select;
	logic [3:0]             pixel_index;
	logic [COLOR_W-1:0]     red_level;
	logic [COLOR_W-1:0]     green_level;
	logic [COLOR_W-1:0]     blue_level;
	logic                   last_write;
	int                     fail_count;
	int                     pending;

	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	logic hold_req = 1'b0;
	logic hold_taken = 1'b0;
	int hold_left = 0;

	led_trail_pattern_generator uut (.*);

	ltpg_write_checker checker_i (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#5ms;
		$display("** led_trail_pattern_generator: FAILED **");
		$finish;
	end

	// Output side: random stalls, plus one long hold-off when asked for.
	always @(posedge clk) begin
		if (hold_req && !hold_taken) begin
			hold_taken <= 1'b1;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < rx_idle_pct);
		end
	end

	// Offers one request and returns at the edge that accepts it.
	task automatic send_request(input logic rst_bit);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		restart <= rst_bit;
		do @(posedge clk); while (in_stall);
	endtask

	// Waits until every predicted write has left and the block is quiet.
	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_write_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
	endtask

	// Loads a full trail setting once the block is idle; the unused index is
	// written too, and must be ignored.
	task automatic program_trail(input logic [7:0] len, input logic [7:0] sr,
			input logic [7:0] sg, input logic [7:0] sb, input logic [7:0] er,
			input logic [7:0] eg, input logic [7:0] eb);
		settle();
		write_reg(REG_TRAIL_LENGTH, len);
		write_reg(REG_START_RED, sr);
		write_reg(REG_START_GREEN, sg);
		write_reg(REG_START_BLUE, sb);
		write_reg(REG_END_RED, er);
		write_reg(REG_END_GREEN, eg);
		write_reg(REG_END_BLUE, eb);
		write_reg(REG_UNUSED, 8'($urandom_range(255)));
		cfg_write_en <= 1'b0;
	endtask

	function automatic logic [7:0] pick_level();
		case ($urandom_range(3))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	// Mostly short trails; now and then the clamp edges or junk upper bits.
	function automatic logic [7:0] pick_length();
		case ($urandom_range(19))
			0: return 8'd0;
			1: return 8'd1;
			2: return 8'd2;
			3: return 8'd47;
			4: return 8'd48;
			5: return 8'd49;
			6: return 8'd63;
			7: return 8'($urandom_range(64, 255));
			default: return 8'($urandom_range(2, 16));
		endcase
	endfunction

	initial begin
		int phase;
		int sent;
		int seg;
		int restart_pct;
		int waited;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: first tick has no blanking, the second one does.
		send_request(1'b0);
		send_request(1'b0);
		send_request(1'b1);
		send_request(1'b0);
		send_request(1'b0);

		// Lengths below the range clamp to two.
		program_trail(8'd0, 8'd255, 8'd0, 8'd128, 8'd0, 8'd255, 8'd128);
		send_request(1'b0);
		send_request(1'b0);
		program_trail(8'd1, 8'd255, 8'd0, 8'd128, 8'd0, 8'd255, 8'd128);
		send_request(1'b0);

		// Full ring with falling colours, behind a long output hold-off.
		program_trail(8'd48, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0);
		hold_req <= 1'b1;
		send_request(1'b0);
		send_request(1'b0);
		send_request(1'b0);

		// Lengths above the range clamp to the maximum; rising colours.
		program_trail(8'd49, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255);
		send_request(1'b0);
		send_request(1'b0);
		program_trail(8'hFF, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255);
		send_request(1'b1);
		send_request(1'b0);
		send_request(1'b0);
		program_trail(8'd2, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0);
		send_request(1'b0);
		send_request(1'b0);
		program_trail(8'd47, pick_level(), pick_level(), pick_level(), pick_level(),
			pick_level(), pick_level());
		send_request(1'b0);

		// Random segments under three idling patterns.
		for (phase = 0; phase < 3; phase++) begin
			tx_idle_pct = (phase == 0) ? 31 : (phase == 1) ? 56 : 0;
			rx_idle_pct = (phase == 0) ? 56 : (phase == 1) ? 31 : 0;
			sent = 0;
			while (sent < RANDOM_TICKS / 3) begin
				program_trail(pick_length(), pick_level(), pick_level(), pick_level(),
					pick_level(), pick_level(), pick_level());
				seg = $urandom_range(10, 40);
				// The last segment of a phase only tops up to the phase total.
				if (seg > RANDOM_TICKS / 3 - sent)
					seg = RANDOM_TICKS / 3 - sent;
				case ($urandom_range(2))
					0: restart_pct = 0;
					1: restart_pct = 3;
					default: restart_pct = 15;
				endcase
				repeat (seg) send_request($urandom_range(99) < restart_pct);
				sent += seg;
			end
		end

		// Drain the remaining writes.
		in_valid <= 1'b0;
		@(posedge clk);
		for (waited = 0; pending != 0 && waited < DRAIN_LIMIT; waited++)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("** led_trail_pattern_generator: PASSED **");
		else
			$display("** led_trail_pattern_generator: FAILED **");
		$finish;
	end

endmodule

// ===== sim.f =====
src/ltpg_pkg.sv
src/led_trail_pattern_generator.sv
src/ltpg_checker.sv
sim/ltpg_write_checker.sv
sim/testbench.sv
